// File: rtl/wto_pkg.sv
// Package: wavetable oscillator constants, register codes and waveform ROM function.
package wto_pkg;

    localparam int TABLE_SIZE_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int PHASE_WIDTH_DEF  = 32;
    localparam int FRAC_BITS        = 16;
    localparam int ROM_BITS         = 8;
    localparam int INC_WIDTH        = 32;
    localparam int AMP_WIDTH        = 16;
    localparam int WAVE_WIDTH       = 3;
    localparam int OUT_WIDTH        = 16;
    localparam int ADDR_WIDTH       = 4;

    localparam logic [ADDR_WIDTH-3:0] REG_WAVE = 2'd0;
    localparam logic [ADDR_WIDTH-3:0] REG_INC  = 2'd1;
    localparam logic [ADDR_WIDTH-3:0] REG_AMP  = 2'd2;

    localparam logic [WAVE_WIDTH-1:0] WAVE_SAW  = 3'd0;
    localparam logic [WAVE_WIDTH-1:0] WAVE_RSAW = 3'd1;
    localparam logic [WAVE_WIDTH-1:0] WAVE_SQR  = 3'd2;
    localparam logic [WAVE_WIDTH-1:0] WAVE_SINE = 3'd3;
    localparam logic [WAVE_WIDTH-1:0] WAVE_TRI  = 3'd4;

    localparam logic [INC_WIDTH-1:0] INC_RESET = 32'd39370534;
    localparam logic [AMP_WIDTH-1:0] AMP_RESET = 16'd32768;

    localparam logic [15:0] QSINE [0:64] = '{
        16'd0, 16'd804, 16'd1608, 16'd2411, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
        16'd6393, 16'd7180, 16'd7962, 16'd8740, 16'd9512, 16'd10279, 16'd11039,
        16'd11793, 16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151,
        16'd16846, 16'd17531, 16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788,
        16'd21403, 16'd22006, 16'd22595, 16'd23170, 16'd23732, 16'd24279, 16'd24812,
        16'd25330, 16'd25833, 16'd26320, 16'd26791, 16'd27246, 16'd27684, 16'd28106,
        16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957, 16'd30274, 16'd30572,
        16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972, 16'd32138,
        16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
        16'd32768
    };

    function automatic logic signed [15:0] sat_pos(input logic [15:0] v);
        sat_pos = (v == 16'd32768) ? 16'sd32767 : $signed(v);
    endfunction

    function automatic logic signed [15:0] rom_read(input logic [WAVE_WIDTH-1:0] wave,
                                                    input logic [ROM_BITS-1:0] s);
        logic signed [17:0] t;
        logic [7:0] d;
        t = '0;
        d = '0;
        rom_read = '0;
        unique case (wave)
            WAVE_SAW:
            begin
                t = ($signed({10'd0, s}) - 18'sd127) <<< 8;
                rom_read = (t > 18'sd32767) ? 16'sd32767 : t[15:0];
            end
            WAVE_RSAW:
            begin
                t = (18'sd127 - $signed({10'd0, s})) <<< 8;
                rom_read = t[15:0];
            end
            WAVE_SQR:
                rom_read = s[7] ? -16'sd32768 : 16'sd32767;
            WAVE_SINE:
            begin
                if (s <= 8'd64)
                    rom_read = sat_pos(QSINE[s[6:0]]);
                else if (s <= 8'd128)
                begin
                    d = 8'd128 - s;
                    rom_read = sat_pos(QSINE[d[6:0]]);
                end
                else if (s <= 8'd192)
                begin
                    d = s - 8'd128;
                    rom_read = -$signed(QSINE[d[6:0]]);
                end
                else
                begin
                    d = 8'd0 - s;
                    rom_read = -$signed(QSINE[d[6:0]]);
                end
            end
            WAVE_TRI:
            begin
                if (!s[7])
                begin
                    t = ($signed({10'd0, s}) - 18'sd63) <<< 9;
                    rom_read = (t > 18'sd32767) ? 16'sd32767 : t[15:0];
                end
                else
                begin
                    t = (18'sd191 - $signed({10'd0, s})) <<< 9;
                    rom_read = t[15:0];
                end
            end
            default:
                rom_read = '0;
        endcase
    endfunction

endpackage

// File: rtl/wto_mac.sv
// Shared signed multiply-accumulate unit used by the oscillator sequencer.
module wto_mac
    import wto_pkg::*;
(
    input  logic                clk,
    input  logic                clear,
    input  logic                load,
    input  logic signed [17:0]  a,
    input  logic signed [17:0]  b,
    output logic signed [39:0]  acc
);

    logic signed [39:0] acc_reg;
    logic signed [39:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
            acc_next = 40'(a * b);
        else if (load)
            acc_next = acc_reg + 40'(a * b);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: rtl/wavetable_oscillator_interp.sv
// Top level: wavetable oscillator with linear interpolation and APB register port.
//
// Input channel (in_valid, in_stall, enable): one transfer is one sample tick.
// Output channel (out_valid, out_stall, sample): one transfer per input tick.
// Registers over APB: wave_select at 0x0, phase_increment at 0x4, amplitude
// at 0x8; pready is tied high and reads return the stored value.
// An enabled tick steps through ST_IDLE, ST_HI, ST_AMP and ST_OUT on one shared
// 18x18 multiplier: the lower table weight, the upper table weight, then the
// amplitude scale, then the result is registered. A disabled tick is handled in
// ST_IDLE alone. The multiplier sets the rate: a new tick waits for ST_IDLE.
// The input stalls while a tick is in progress; a finished sample sits in the
// output register, and the next enabled tick is accepted while it waits, but
// its result is held until the output register drains. A disabled tick is
// stalled until the waiting sample is taken.
// Reset clears the phase, restores the register defaults and empties the
// output register.
module wavetable_oscillator_interp
    import wto_pkg::*;
#(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int PHASE_WIDTH  = PHASE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  enable,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [OUT_WIDTH-1:0] sample,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_BITS = $clog2(TABLE_SIZE);
    localparam int SHR      = 31 - SAMPLE_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HI   = 2'd1;
    localparam logic [1:0] ST_AMP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [WAVE_WIDTH-1:0]  wave_reg;
    logic [INC_WIDTH-1:0]   inc_reg;
    logic [AMP_WIDTH-1:0]   amp_reg;
    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [OUT_WIDTH-1:0] sample_reg, sample_next;

    logic                   in_xfer, out_xfer, wr_en;
    logic [IDX_BITS-1:0]    lo_idx, hi_idx;
    logic [FRAC_BITS-1:0]   frac;
    logic [ROM_BITS-1:0]    rom_lo, rom_hi;
    logic [PHASE_WIDTH+IDX_BITS-1:0] pos;
    logic                   mac_clear, mac_load;
    logic signed [17:0]     mac_a, mac_b;
    logic signed [39:0]     acc;
    logic signed [23:0]     interp;
    logic signed [39:0]     res;
    logic signed [SAMPLE_WIDTH-1:0] sat;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall && !enable);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[ADDR_WIDTH-1:2])
            REG_WAVE: prdata = 32'(wave_reg);
            REG_INC:  prdata = inc_reg;
            REG_AMP:  prdata = 32'(amp_reg);
            default:  prdata = '0;
        endcase
    end

    assign pos    = {{IDX_BITS{1'b0}}, phase_reg} << IDX_BITS;
    assign lo_idx = pos[PHASE_WIDTH+IDX_BITS-1:PHASE_WIDTH];
    assign hi_idx = lo_idx + 1'b1;
    assign frac   = pos[PHASE_WIDTH-1:PHASE_WIDTH-FRAC_BITS];
    assign rom_lo = ROM_BITS'((32'(lo_idx) * 256) / TABLE_SIZE);
    assign rom_hi = ROM_BITS'((32'(hi_idx) * 256) / TABLE_SIZE);

    always_comb
    begin
        mac_clear = 1'b0;
        mac_load  = 1'b0;
        mac_a     = '0;
        mac_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mac_clear = 1'b1;
                mac_a = 18'(rom_read(wave_reg, rom_lo));
                mac_b = $signed(18'(18'h10000 - {2'b0, frac}));
            end
            ST_HI:
            begin
                mac_load = 1'b1;
                mac_a = 18'(rom_read(wave_reg, rom_hi));
                mac_b = $signed({2'b0, frac});
            end
            ST_AMP:
            begin
                mac_clear = 1'b1;
                mac_a = 18'(interp);
                mac_b = $signed({2'b0, amp_reg});
            end
            default:
            begin
            end
        endcase
    end

    wto_mac u_mac (
        .clk   (clk),
        .clear (mac_clear),
        .load  (mac_load),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    assign interp = 24'(acc >>> FRAC_BITS);
    assign res    = acc >>> SHR;
    assign sat    = (res > 40'sd0 + ((40'sd1 <<< (SAMPLE_WIDTH-1)) - 1))
                    ? SAMPLE_WIDTH'((40'sd1 <<< (SAMPLE_WIDTH-1)) - 1)
                    : (res < -(40'sd1 <<< (SAMPLE_WIDTH-1)))
                    ? SAMPLE_WIDTH'(-(40'sd1 <<< (SAMPLE_WIDTH-1)))
                    : SAMPLE_WIDTH'(res);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        sample_next    = sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (enable)
                        state_next = ST_HI;
                    else
                    begin
                        phase_next     = '0;
                        out_valid_next = 1'b1;
                        sample_next    = '0;
                    end
                end
            end
            ST_HI:  state_next = ST_AMP;
            ST_AMP: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_xfer)
                begin
                    state_next     = ST_IDLE;
                    phase_next     = phase_reg + PHASE_WIDTH'(inc_reg);
                    out_valid_next = 1'b1;
                    sample_next    = OUT_WIDTH'(sat);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            wave_reg      <= WAVE_SAW;
            inc_reg       <= INC_RESET;
            amp_reg       <= AMP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                unique case (paddr[ADDR_WIDTH-1:2])
                    REG_WAVE: wave_reg <= pwdata[WAVE_WIDTH-1:0];
                    REG_INC:  inc_reg  <= pwdata;
                    REG_AMP:  amp_reg  <= pwdata[AMP_WIDTH-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

endmodule
